/* rtl/scfc_pkg.sv */
package scfc_pkg;

  // Default buffer depth
  localparam int MAX_FRAME_LEN_DEF = 256;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 9;

  // Control codes (ASCII)
  localparam logic [BYTE_W-1:0] C_ETX   = 8'h03;
  localparam logic [BYTE_W-1:0] C_ENQ   = 8'h05;
  localparam logic [BYTE_W-1:0] C_ACK   = 8'h06;
  localparam logic [BYTE_W-1:0] C_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] C_XON   = 8'h11;
  localparam logic [BYTE_W-1:0] C_XOFF  = 8'h13;
  localparam logic [BYTE_W-1:0] C_NACK  = 8'h15;
  localparam logic [BYTE_W-1:0] C_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] C_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] C_QUERY = 8'h3F;

  // Request type
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Framing phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PROT = 3'd1,
    PH_ETX  = 3'd2,
    PH_TEST = 3'd3,
    PH_ONE  = 3'd4
  } phase_t;

  // Frame mode
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PROT  = 2'd1,
    MODE_TLINE = 2'd2,
    MODE_TERM  = 2'd3
  } mode_t;

  // Framing control state
  typedef struct packed {
    phase_t phase;
    mode_t  mode;
  } scfc_ctl_t;

  // Result of one transaction
  typedef struct packed {
    logic              byte_stored;
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  byte_position;
    logic              frame_done;
    mode_t             frame_kind;
    logic [LEN_W-1:0]  frame_length;
  } scfc_res_t;

endpackage

/* rtl/scfc_step.sv */
module scfc_step import scfc_pkg::*; #(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
  parameter int CNT_W         = $clog2(MAX_FRAME_LEN + 1)
) (
  input  logic              req_type,
  input  logic [BYTE_W-1:0] rx_byte,
  input  scfc_ctl_t         ctl,
  input  logic [CNT_W-1:0]  fill,
  output scfc_ctl_t         ctl_next,
  output logic [CNT_W-1:0]  fill_next,
  output scfc_res_t         res
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_LEN);

  logic [CNT_W-1:0] fill_work;
  logic [CNT_W-1:0] fill_after;
  phase_t           phase_w;
  mode_t            mode_w;
  logic             do_append;
  logic             done;
  logic             stored;

  // Framing rules for one received byte
  always_comb begin
    fill_work = fill;
    phase_w   = ctl.phase;
    mode_w    = ctl.mode;
    do_append = 1'b1;
    done      = 1'b0;
    case (ctl.phase)
      PH_PROT: begin
        if (rx_byte == C_ENQ) begin
          fill_work = '0;
          mode_w    = MODE_PROT;
        end else if (rx_byte == C_ETX) begin
          phase_w = PH_ETX;
        end
      end
      PH_ETX: begin
        done = 1'b1;
      end
      PH_TEST: begin
        if (rx_byte == C_ENQ) begin
          fill_work = '0;
          mode_w    = MODE_PROT;
        end else if (rx_byte == C_DASH) begin
          fill_work = '0;
          mode_w    = MODE_TLINE;
        end else if (rx_byte == C_CR) begin
          done = 1'b1;
        end
      end
      PH_ONE: begin
        phase_w = PH_IDLE;
        done    = 1'b1;
      end
      default: begin
        // idle, and unreachable codes behave as idle
        if (rx_byte == C_ENQ) begin
          phase_w   = PH_PROT;
          fill_work = '0;
          mode_w    = MODE_PROT;
        end else if (rx_byte == C_DASH) begin
          if (fill == '0) begin
            mode_w  = MODE_TLINE;
            phase_w = PH_TEST;
          end
        end else if (rx_byte == C_ACK || rx_byte == C_NACK) begin
          mode_w  = MODE_PROT;
          phase_w = PH_ONE;
        end else if (rx_byte == C_BANG || rx_byte == C_QUERY) begin
          if (fill == '0) begin
            if (ctl.mode == MODE_NONE) begin
              mode_w  = MODE_TLINE;
              phase_w = PH_ONE;
            end else if (ctl.mode == MODE_TERM || ctl.mode == MODE_TLINE) begin
              phase_w = PH_ONE;
            end
          end
        end else if (rx_byte == C_CR) begin
          mode_w = MODE_TERM;
          done   = 1'b1;
        end else if (rx_byte == C_XON || rx_byte == C_XOFF) begin
          do_append = 1'b0;
        end
      end
    endcase
  end

  // Append with saturation at the buffer size
  assign stored     = do_append && (fill_work < MAX_CNT);
  assign fill_after = stored ? fill_work + CNT_W'(1) : fill_work;

  // Result and next state; timeout and completion re-initialize
  always_comb begin
    res               = '0;
    ctl_next.phase    = PH_IDLE;
    ctl_next.mode     = MODE_NONE;
    fill_next         = '0;
    if (req_type == REQ_BYTE) begin
      res.byte_stored   = stored;
      res.byte_out      = stored ? rx_byte : '0;
      res.byte_position = stored ? POS_W'(fill_work) : '0;
      res.frame_done    = done;
      res.frame_kind    = done ? mode_w : MODE_NONE;
      res.frame_length  = LEN_W'(fill_after);
      if (!done) begin
        ctl_next.phase = phase_w;
        ctl_next.mode  = mode_w;
        fill_next      = fill_after;
      end
    end
  end

endmodule

/* rtl/serial_command_frame_collector_top.sv */
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, rx_byte
// out      out_valid / out_ready byte_stored, byte_out, byte_position,
//                                frame_done, frame_kind, frame_length
//
// One transaction per cycle sustained while the output is not stalled; an accepted
// transaction sits in the input register, and its result register loads when the
// output can take it, which also raises out_valid.
// The framing state updates in the same cycle the result register loads.
// Synchronous reset returns phase, mode and fill count to idle/empty.
// A stalled output holds the result; the input register fills once more,
// then in_ready drops until out_ready returns.
module serial_command_frame_collector_top import scfc_pkg::*; #(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              byte_stored,
  output logic [BYTE_W-1:0] byte_out,
  output logic [POS_W-1:0]  byte_position,
  output logic              frame_done,
  output logic [1:0]        frame_kind,
  output logic [LEN_W-1:0]  frame_length
);

  localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

  // Input register
  logic              s1_valid;
  logic              s1_req;
  logic [BYTE_W-1:0] s1_byte;

  // Framing state
  scfc_ctl_t         ctl;
  logic [CNT_W-1:0]  fill;
  scfc_ctl_t         ctl_next;
  logic [CNT_W-1:0]  fill_next;

  // Result register
  scfc_res_t         res_next;
  scfc_res_t         res;

  logic              s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  scfc_step #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .CNT_W         (CNT_W)
  ) u_step (
    .req_type  (s1_req),
    .rx_byte   (s1_byte),
    .ctl       (ctl),
    .fill      (fill),
    .ctl_next  (ctl_next),
    .fill_next (fill_next),
    .res       (res_next)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_req  <= req_type;
      s1_byte <= rx_byte;
    end
  end

  // Framing state and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase <= PH_IDLE;
      ctl.mode  <= MODE_NONE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        ctl       <= ctl_next;
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign byte_stored   = res.byte_stored;
  assign byte_out      = res.byte_out;
  assign byte_position = res.byte_position;
  assign frame_done    = res.frame_done;
  assign frame_kind    = res.frame_kind;
  assign frame_length  = res.frame_length;

  // Completion always reports a frame mode, and only completion does
  a_kind_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_done == (frame_kind != MODE_NONE)))
    else $error("frame_kind does not match frame_done");

  // A byte that was not stored reports zero byte and position
  a_unstored_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_stored) |-> (byte_out == '0 && byte_position == '0))
    else $error("unstored byte reports data");

  // Fill count saturates at the buffer size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_FRAME_LEN))
    else $error("fill count beyond buffer size");

  // Timeout or completion re-initializes the framing state
  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && (s1_req == REQ_TIMEOUT || res_next.frame_done))
    |=> (fill == '0 && ctl.phase == PH_IDLE && ctl.mode == MODE_NONE))
    else $error("state not re-initialized");

endmodule

/* bench/serial_command_frame_collector_top_tb.sv */
`timescale 1ns / 1ps
module serial_command_frame_collector_top_tb;
  import scfc_pkg::*;

  localparam int FRAME_CAP    = MAX_FRAME_LEN_DEF;
  localparam int HOLD_CYCLES  = 60;
  localparam int WATCHDOG_MAX = 2000;
  localparam int TAIL_LAT     = 10;

  typedef struct packed {
    logic              req;
    logic [BYTE_W-1:0] b;
  } rx_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              req_type = REQ_BYTE;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              byte_stored;
  logic [BYTE_W-1:0] byte_out;
  logic [POS_W-1:0]  byte_position;
  logic              frame_done;
  logic [1:0]        frame_kind;
  logic [LEN_W-1:0]  frame_length;

  // Framing state mirrored by the predictor
  phase_t fr_phase = PH_IDLE;
  mode_t  fr_mode  = MODE_NONE;
  int     fr_fill  = 0;

  rx_item_t  rx_backlog[$];
  scfc_res_t pending_results[$];

  int   pushed = 0;
  int   accepted = 0;
  int   errors = 0;
  int   cyc = 0;
  int   quiet_cycles = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  serial_command_frame_collector_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_stored   (byte_stored),
    .byte_out      (byte_out),
    .byte_position (byte_position),
    .frame_done    (frame_done),
    .frame_kind    (frame_kind),
    .frame_length  (frame_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Store one byte unless the buffer is full
  function automatic void frame_append(input logic [BYTE_W-1:0] b, inout scfc_res_t r);
    if (fr_fill < FRAME_CAP) begin
      r.byte_stored   = 1'b1;
      r.byte_out      = b;
      r.byte_position = POS_W'(fr_fill);
      fr_fill++;
    end
  endfunction

  // Expected result of one transaction; advances the mirrored framing state
  function automatic scfc_res_t collect_byte(input logic req, input logic [BYTE_W-1:0] b);
    scfc_res_t r;
    logic      done;
    r = '0;
    done = 1'b0;
    if (req == REQ_TIMEOUT) begin
      fr_phase = PH_IDLE;
      fr_mode  = MODE_NONE;
      fr_fill  = 0;
      return r;
    end
    case (fr_phase)
      PH_PROT: begin
        if (b == C_ENQ) begin
          fr_fill = 0;
          fr_mode = MODE_PROT;
        end else if (b == C_ETX) begin
          fr_phase = PH_ETX;
        end
        frame_append(b, r);
      end
      PH_ETX: begin
        frame_append(b, r);
        done = 1'b1;
      end
      PH_TEST: begin
        if (b == C_ENQ) begin
          fr_fill = 0;
          fr_mode = MODE_PROT;
        end else if (b == C_DASH) begin
          fr_fill = 0;
          fr_mode = MODE_TLINE;
        end else if (b == C_CR) begin
          done = 1'b1;
        end
        frame_append(b, r);
      end
      PH_ONE: begin
        fr_phase = PH_IDLE;
        frame_append(b, r);
        done = 1'b1;
      end
      default: begin
        if (b == C_ENQ) begin
          fr_phase = PH_PROT;
          fr_fill  = 0;
          fr_mode  = MODE_PROT;
          frame_append(b, r);
        end else if (b == C_DASH) begin
          // only a leading dash opens a test line
          if (fr_fill == 0) begin
            fr_mode  = MODE_TLINE;
            fr_phase = PH_TEST;
          end
          frame_append(b, r);
        end else if (b == C_ACK || b == C_NACK) begin
          fr_mode  = MODE_PROT;
          fr_phase = PH_ONE;
          frame_append(b, r);
        end else if (b == C_BANG || b == C_QUERY) begin
          if (fr_fill == 0) begin
            if (fr_mode == MODE_NONE) begin
              fr_mode  = MODE_TLINE;
              fr_phase = PH_ONE;
            end else if (fr_mode == MODE_TERM || fr_mode == MODE_TLINE) begin
              fr_phase = PH_ONE;
            end
          end
          frame_append(b, r);
        end else if (b == C_CR) begin
          fr_mode = MODE_TERM;
          frame_append(b, r);
          done = 1'b1;
        end else if (b != C_XON && b != C_XOFF) begin
          frame_append(b, r);
        end
      end
    endcase
    r.frame_length = LEN_W'(fr_fill);
    if (done) begin
      r.frame_done = 1'b1;
      r.frame_kind = fr_mode;
      fr_phase = PH_IDLE;
      fr_mode  = MODE_NONE;
      fr_fill  = 0;
    end
    return r;
  endfunction

  task automatic push_item(input logic req, input logic [BYTE_W-1:0] b);
    rx_item_t it;
    it.req = req;
    it.b   = b;
    rx_backlog.push_back(it);
    pushed++;
  endtask

  // Mostly printable payload, sometimes any byte
  function automatic logic [BYTE_W-1:0] text_byte();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(32, 126));
  endfunction

  function automatic logic [BYTE_W-1:0] ctrl_byte();
    case ($urandom_range(0, 9))
      0: return C_ETX;
      1: return C_ENQ;
      2: return C_ACK;
      3: return C_CR;
      4: return C_XON;
      5: return C_XOFF;
      6: return C_NACK;
      7: return C_DASH;
      8: return C_BANG;
      default: return C_QUERY;
    endcase
  endfunction

  // Payload bytes, now and then cut short by an idle timeout
  task automatic push_text(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 79) == 0) push_item(REQ_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
      else push_item(REQ_BYTE, text_byte());
    end
  endtask

  // One random frame: mostly well formed, some noise and timeouts
  task automatic push_frame();
    int kind;
    int n;
    int i;
    kind = $urandom_range(0, 9);
    n = ($urandom_range(0, 149) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
    case (kind)
      0, 1: begin
        push_item(REQ_BYTE, C_ENQ);
        push_text(n);
        push_item(REQ_BYTE, C_ETX);
        push_item(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
      2: begin
        push_item(REQ_BYTE, C_DASH);
        push_text(n);
        push_item(REQ_BYTE, C_CR);
      end
      3: begin
        push_item(REQ_BYTE, $urandom_range(0, 1) ? C_ACK : C_NACK);
        push_item(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
      4: begin
        push_item(REQ_BYTE, $urandom_range(0, 1) ? C_BANG : C_QUERY);
        push_item(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
      5, 6: begin
        push_text(n);
        push_item(REQ_BYTE, C_CR);
      end
      7: begin
        for (i = 0; i < n; i++) push_item(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
      8: begin
        for (i = 0; i < n; i++) push_item(REQ_BYTE, ctrl_byte());
      end
      default: push_item(REQ_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
    endcase
  endtask

  // Sequence control
  initial begin
    int i;
    // plain byte, non-leading bang, terminal line
    push_item(REQ_BYTE, 8'h00);
    push_item(REQ_BYTE, C_BANG);
    push_item(REQ_BYTE, C_CR);
    // protected block with a restart, then the check byte
    push_item(REQ_BYTE, C_ENQ);
    push_item(REQ_BYTE, 8'hFF);
    push_item(REQ_BYTE, C_ENQ);
    push_item(REQ_BYTE, C_ETX);
    push_item(REQ_BYTE, 8'h80);
    // test line restarted by ENQ and then by dash
    push_item(REQ_BYTE, C_DASH);
    push_item(REQ_BYTE, 8'h41);
    push_item(REQ_BYTE, C_ENQ);
    push_item(REQ_BYTE, C_DASH);
    push_item(REQ_BYTE, C_CR);
    // one-more-byte frames
    push_item(REQ_BYTE, C_ACK);
    push_item(REQ_BYTE, 8'h7F);
    push_item(REQ_BYTE, C_NACK);
    push_item(REQ_BYTE, 8'h55);
    push_item(REQ_BYTE, C_QUERY);
    push_item(REQ_BYTE, 8'hAA);
    // flow control dropped, timeout
    push_item(REQ_BYTE, C_XON);
    push_item(REQ_BYTE, C_XOFF);
    push_item(REQ_TIMEOUT, 8'hFF);
    // dash after the first byte stays in idle
    push_item(REQ_BYTE, 8'h78);
    push_item(REQ_BYTE, C_DASH);
    push_item(REQ_BYTE, C_CR);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (accepted != pushed || pending_results.size() != 0) @(negedge clk);
    @(posedge clk);

    // long receiver hold while an overlong terminal line keeps coming
    hold_req = 1'b1;
    push_item(REQ_BYTE, 8'h61);
    for (i = 1; i < 280; i++) begin
      push_item(REQ_BYTE, (i == 270) ? C_DASH : BYTE_W'($urandom_range(32, 126)));
    end
    push_item(REQ_BYTE, C_CR);
    while (pushed < 800) push_frame();

    // sender pauses until everything has drained
    while (accepted != pushed || pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
    while (pushed < 1400) push_frame();

    // last stretch without idling
    while (rx_backlog.size() != 0) @(negedge clk);
    @(posedge clk);
    quiet = 1'b1;
    while (pushed < 1550) push_frame();

    while (accepted != pushed || pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_LAT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS serial_command_frame_collector_top");
    end else begin
      $display("FAIL serial_command_frame_collector_top");
    end
    $finish;
  end

  // Input driver
  always @(negedge clk) begin
    rx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && !cyc[7] && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
        it = rx_backlog.pop_front();
        in_valid <= 1'b1;
        req_type <= it.req;
        rx_byte  <= it.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result consumer backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && (cyc[6] ^ cyc[8]) && $urandom_range(0, 5) == 0) begin
      recv_gap  <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk) begin
    scfc_res_t want;
    scfc_res_t got;
    cyc <= cyc + 1;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        pending_results.push_back(collect_byte(req_type, rx_byte));
        accepted++;
      end
      if (out_valid && out_ready) begin
        got = {byte_stored, byte_out, byte_position, frame_done, mode_t'(frame_kind),
               frame_length};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: stored=%0d byte=%02h pos=%0d done=%0d",
                   $time, byte_stored, byte_out, byte_position, frame_done);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected stored=%0d byte=%02h pos=%0d done=%0d kind=%0d len=%0d",
                     $time, want.byte_stored, want.byte_out, want.byte_position,
                     want.frame_done, want.frame_kind, want.frame_length);
            $display("%0t:          actual   stored=%0d byte=%02h pos=%0d done=%0d kind=%0d len=%0d",
                     $time, got.byte_stored, got.byte_out, got.byte_position,
                     got.frame_done, got.frame_kind, got.frame_length);
          end
        end
      end
      // watchdog on cycles with no transaction on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("FAIL serial_command_frame_collector_top");
        $finish;
      end
    end
  end

endmodule
